// File: hw/rtl/rfbp_pkg.sv
// ----------------------------------------------------------------------------
// RFB server stream parser package
// Shared types, message codes and field offsets of the parser.
// ----------------------------------------------------------------------------
package rfbp_pkg;

  typedef enum logic [3:0] {
    PH_TYPE,
    PH_FBU,
    PH_RECT,
    PH_RAW,
    PH_COPY,
    PH_CMAP,
    PH_CUT,
    PH_SKIP,
    PH_HALT
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_COPY  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  localparam logic [7:0] MSG_FBU  = 8'd0;
  localparam logic [7:0] MSG_CMAP = 8'd1;
  localparam logic [7:0] MSG_BELL = 8'd2;
  localparam logic [7:0] MSG_CUT  = 8'd3;

  localparam logic [31:0] ENC_RAW  = 32'd0;
  localparam logic [31:0] ENC_COPY = 32'd1;

  localparam logic ERR_MSG_TYPE = 1'b0;
  localparam logic ERR_ENCODING = 1'b1;

  localparam int RECT_HDR_BYTES = 12;
  localparam int CMAP_HDR_BYTES = 5;
  localparam int CUT_HDR_BYTES  = 7;

  localparam logic [3:0] IDX_FBU_COUNT = 4'd2;
  localparam logic [3:0] IDX_RECT_X    = 4'd1;
  localparam logic [3:0] IDX_RECT_Y    = 4'd3;
  localparam logic [3:0] IDX_RECT_W    = 4'd5;
  localparam logic [3:0] IDX_RECT_H    = 4'd7;
  localparam logic [3:0] IDX_RECT_ENC  = 4'(RECT_HDR_BYTES - 1);
  localparam logic [3:0] IDX_COPY_SRC  = 4'd3;
  localparam logic [3:0] IDX_CMAP_CNT  = 4'(CMAP_HDR_BYTES - 1);
  localparam logic [3:0] IDX_CUT_LEN   = 4'(CUT_HDR_BYTES - 1);

  // Output word layout.
  localparam int M_DATA_W    = 120;
  localparam int ROW_END_BIT = 112;
  localparam int ERR_BIT     = 113;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pixel_value;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [15:0] source_x;
    logic [15:0] source_y;
    logic        row_end;
    logic        update_end;
    logic        error_code;
  } result_t;

endpackage

// File: hw/rtl/rfb_server_stream_parser_top.sv
// ----------------------------------------------------------------------------
// RFB server stream parser
// Parses the server-to-client stream of the remote framebuffer protocol.
// ----------------------------------------------------------------------------
// The parser takes one byte word in every cycle unless the result side stalls,
// and gives at most one result word per byte. The byte is held in the input
// register, the parse state is updated once per byte as it leaves, and the
// result is held in the result register. Raw pixels come out once per two bytes,
// copy rectangles once their source coordinates arrive, and an update with no
// rectangles gives one word of its own. After an error word the parser ignores
// all input until reset. A stalled result word holds the input side only once
// the input register is also full.
module rfb_server_stream_parser_top import rfbp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // data_byte
  input  logic [7:0]          s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // pos_x, pos_y, pixel_value, rect_width, rect_height, source_x, source_y,
  // row_end, error_code, zero fill
  output logic [M_DATA_W-1:0] m_axis_tdata,
  // kind
  output logic [1:0]          m_axis_tuser,
  // update_end
  output logic                m_axis_tlast
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       advance;
  logic       out_valid_q, out_valid_d;
  result_t    out_res_q;
  logic       core_valid;
  result_t    core_res;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = core_valid;
    end
  end

  rfbp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(in_valid_q && advance),
    .byte_i      (in_byte_q),
    .res_valid_o (core_valid),
    .res_o       (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance && core_valid) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.kind;
  assign m_axis_tlast  = out_res_q.update_end;
  assign m_axis_tdata  = {6'd0, out_res_q.error_code, out_res_q.row_end,
                          out_res_q.source_y, out_res_q.source_x,
                          out_res_q.rect_height, out_res_q.rect_width,
                          out_res_q.pixel_value, out_res_q.pos_y, out_res_q.pos_x};

endmodule

// File: hw/rtl/rfbp_core.sv
// ----------------------------------------------------------------------------
// RFB server stream parser core
// Holds the parse state and turns one registered byte into at most one result.
// ----------------------------------------------------------------------------
module rfbp_core import rfbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;
  logic [31:0] shift_q, shift_d;
  logic [15:0] rects_q, rects_d;
  logic [15:0] hx_q, hx_d, hy_q, hy_d, hw_q, hw_d, hh_q, hh_d;
  logic [15:0] col_q, col_d, row_q, row_d;
  logic [7:0]  low_q, low_d;
  logic [31:0] skip_q, skip_d;

  logic [31:0] shift_in;
  logic [15:0] rects_dec;
  logic        last_col, last_row;
  logic [18:0] cmap_bytes;
  logic        enter_en;
  phase_e      enter_ph;
  logic        res_valid;
  result_t     res;

  assign shift_in   = {shift_q[23:0], byte_i};
  assign rects_dec  = rects_q - 16'd1;
  assign last_col   = ({1'b0, col_q} + 17'd1) == {1'b0, hw_q};
  assign last_row   = ({1'b0, row_q} + 17'd1) == {1'b0, hh_q};
  assign cmap_bytes = {1'b0, shift_in[15:0], 2'b00} + {2'b00, shift_in[15:0], 1'b0};

  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q + 4'd1;
    shift_d   = shift_in;
    rects_d   = rects_q;
    hx_d      = hx_q;
    hy_d      = hy_q;
    hw_d      = hw_q;
    hh_d      = hh_q;
    col_d     = col_q;
    row_d     = row_q;
    low_d     = low_q;
    skip_d    = skip_q;
    enter_en  = 1'b0;
    enter_ph  = phase_q;
    res_valid = 1'b0;
    res       = '0;

    case (phase_q)
      PH_TYPE: begin
        enter_en = 1'b1;
        case (byte_i)
          MSG_FBU:  enter_ph = PH_FBU;
          MSG_CMAP: enter_ph = PH_CMAP;
          MSG_BELL: enter_ph = PH_TYPE;
          MSG_CUT:  enter_ph = PH_CUT;
          default: begin
            enter_ph       = PH_HALT;
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_MSG_TYPE;
          end
        endcase
      end
      PH_FBU: begin
        if (idx_q == IDX_FBU_COUNT) begin
          rects_d  = shift_in[15:0];
          enter_en = 1'b1;
          if (shift_in[15:0] == 16'd0) begin
            enter_ph       = PH_TYPE;
            res_valid      = 1'b1;
            res.kind       = KIND_EMPTY;
            res.update_end = 1'b1;
          end else begin
            enter_ph = PH_RECT;
          end
        end
      end
      PH_RECT: begin
        if (idx_q == IDX_RECT_X) begin
          hx_d = shift_in[15:0];
        end else if (idx_q == IDX_RECT_Y) begin
          hy_d = shift_in[15:0];
        end else if (idx_q == IDX_RECT_W) begin
          hw_d = shift_in[15:0];
        end else if (idx_q == IDX_RECT_H) begin
          hh_d = shift_in[15:0];
        end else if (idx_q == IDX_RECT_ENC) begin
          enter_en = 1'b1;
          if (shift_in == ENC_RAW) begin
            col_d = '0;
            row_d = '0;
            if (hw_q == 16'd0 || hh_q == 16'd0) begin
              rects_d  = rects_dec;
              enter_ph = (rects_dec == 16'd0) ? PH_TYPE : PH_RECT;
            end else begin
              enter_ph = PH_RAW;
            end
          end else if (shift_in == ENC_COPY) begin
            enter_ph = PH_COPY;
          end else begin
            enter_ph       = PH_HALT;
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_ENCODING;
          end
        end
      end
      PH_RAW: begin
        if (!idx_q[0]) begin
          low_d = byte_i;
        end else begin
          res_valid       = 1'b1;
          res.kind        = KIND_PIXEL;
          res.pos_x       = hx_q + col_q;
          res.pos_y       = hy_q + row_q;
          res.pixel_value = {byte_i, low_q};
          res.row_end     = last_col;
          res.update_end  = last_col && last_row && (rects_q == 16'd1);
          idx_d           = '0;
          if (last_col) begin
            col_d = '0;
            row_d = row_q + 16'd1;
            if (last_row) begin
              rects_d  = rects_dec;
              enter_en = 1'b1;
              enter_ph = (rects_dec == 16'd0) ? PH_TYPE : PH_RECT;
            end
          end else begin
            col_d = col_q + 16'd1;
          end
        end
      end
      PH_COPY: begin
        if (idx_q == IDX_COPY_SRC) begin
          res_valid       = 1'b1;
          res.kind        = KIND_COPY;
          res.pos_x       = hx_q;
          res.pos_y       = hy_q;
          res.rect_width  = hw_q;
          res.rect_height = hh_q;
          res.source_x    = shift_in[31:16];
          res.source_y    = shift_in[15:0];
          res.update_end  = rects_q == 16'd1;
          rects_d         = rects_dec;
          enter_en        = 1'b1;
          enter_ph        = (rects_dec == 16'd0) ? PH_TYPE : PH_RECT;
        end
      end
      PH_CMAP: begin
        if (idx_q == IDX_CMAP_CNT) begin
          skip_d   = {13'd0, cmap_bytes};
          enter_en = 1'b1;
          enter_ph = (cmap_bytes == 19'd0) ? PH_TYPE : PH_SKIP;
        end
      end
      PH_CUT: begin
        if (idx_q == IDX_CUT_LEN) begin
          skip_d   = shift_in;
          enter_en = 1'b1;
          enter_ph = (shift_in == 32'd0) ? PH_TYPE : PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_d = skip_q - 32'd1;
        if (skip_d == 32'd0) begin
          enter_en = 1'b1;
          enter_ph = PH_TYPE;
        end
      end
      default: begin
        enter_en = 1'b1;
        enter_ph = PH_HALT;
      end
    endcase

    if (enter_en) begin
      phase_d = enter_ph;
      idx_d   = '0;
      shift_d = '0;
    end
  end

  assign res_valid_o = byte_valid_i && res_valid;
  assign res_o       = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      idx_q   <= '0;
      shift_q <= '0;
      rects_q <= '0;
      hx_q    <= '0;
      hy_q    <= '0;
      hw_q    <= '0;
      hh_q    <= '0;
      col_q   <= '0;
      row_q   <= '0;
      low_q   <= '0;
      skip_q  <= '0;
    end else if (byte_valid_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
      rects_q <= rects_d;
      hx_q    <= hx_d;
      hy_q    <= hy_d;
      hw_q    <= hw_d;
      hh_q    <= hh_d;
      col_q   <= col_d;
      row_q   <= row_d;
      low_q   <= low_d;
      skip_q  <= skip_d;
    end
  end

endmodule

// File: hw/rtl/rfbp_checker.sv
// ----------------------------------------------------------------------------
// RFB server stream parser checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module rfbp_checker import rfbp_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [M_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]          m_axis_tuser,
  input logic                m_axis_tlast
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("Result word changed while stalled.");

  a_halt_after_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_ERROR |=> !m_axis_tvalid)
    else $error("Result word followed an error word.");

  a_empty_ends_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_EMPTY |-> m_axis_tlast)
    else $error("Empty update word without update end.");

  a_pixel_end_is_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_PIXEL && m_axis_tlast
      |-> m_axis_tdata[ROW_END_BIT])
    else $error("Last pixel of an update is not a row end.");

  a_error_no_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_ERROR |-> !m_axis_tlast
      && !m_axis_tdata[ROW_END_BIT])
    else $error("Error word carries end flags.");

endmodule

bind rfb_server_stream_parser_top rfbp_checker u_rfbp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// RFB server stream parser testbench
// Feeds framebuffer updates, color maps, cut text and bell messages into the
// parser byte by byte with random gaps and output stalls. It predicts every
// result word and checks it field by field. The run ends with a parser error.
// ----------------------------------------------------------------------------
module testbench;
  import rfbp_pkg::*;

  localparam int CMAP_ENTRY_BYTES = 6;
  localparam int CLK_HALF         = 6;
  localparam int TIMEOUT_CYCLES   = 400000;
  localparam int DRAIN_CYCLES     = 20;
  localparam int RANDOM_ITEMS     = 1400;
  localparam int QUIET_TAIL       = 200;

  // Tracks the parse state of the stream and holds the result words it implies.
  class parse_tracker;
    phase_e      ph;
    logic [3:0]  fidx;
    logic [31:0] fshift;
    logic [15:0] rleft;
    logic [15:0] hx, hy, hw, hh;
    logic [15:0] col, row;
    logic [7:0]  lowb;
    logic [31:0] skip;
    result_t     pending_results[$];
    int          bad_words;

    function new();
      ph = PH_TYPE;
      fidx = '0;
      fshift = '0;
      rleft = '0;
      hx = '0;
      hy = '0;
      hw = '0;
      hh = '0;
      col = '0;
      row = '0;
      lowb = '0;
      skip = '0;
      bad_words = 0;
    endfunction

    function void enter_phase(phase_e p);
      ph = p;
      fidx = '0;
      fshift = '0;
    endfunction

    function void close_rect();
      rleft = rleft - 16'd1;
      enter_phase(rleft == 16'd0 ? PH_TYPE : PH_RECT);
    endfunction

    function void begin_skip(logic [31:0] n);
      skip = n;
      enter_phase(n == 32'd0 ? PH_TYPE : PH_SKIP);
    endfunction

    function void take_byte(logic [7:0] b);
      result_t    r;
      logic [3:0] i;
      logic       lc, lr;
      bit         has;
      r = '0;
      i = fidx;
      has = 1'b0;
      fshift = {fshift[23:0], b};
      fidx = i + 4'd1;
      case (ph)
        PH_TYPE: begin
          case (b)
            MSG_FBU:  enter_phase(PH_FBU);
            MSG_CMAP: enter_phase(PH_CMAP);
            MSG_BELL: enter_phase(PH_TYPE);
            MSG_CUT:  enter_phase(PH_CUT);
            default: begin
              enter_phase(PH_HALT);
              r.kind = KIND_ERROR;
              r.error_code = ERR_MSG_TYPE;
              has = 1'b1;
            end
          endcase
        end
        PH_FBU: begin
          if (i == IDX_FBU_COUNT) begin
            rleft = fshift[15:0];
            if (rleft == 16'd0) begin
              enter_phase(PH_TYPE);
              r.kind = KIND_EMPTY;
              r.update_end = 1'b1;
              has = 1'b1;
            end else begin
              enter_phase(PH_RECT);
            end
          end
        end
        PH_RECT: begin
          if (i == IDX_RECT_X) hx = fshift[15:0];
          else if (i == IDX_RECT_Y) hy = fshift[15:0];
          else if (i == IDX_RECT_W) hw = fshift[15:0];
          else if (i == IDX_RECT_H) hh = fshift[15:0];
          else if (i == IDX_RECT_ENC) begin
            if (fshift == ENC_RAW) begin
              col = '0;
              row = '0;
              if (hw == 16'd0 || hh == 16'd0) close_rect();
              else enter_phase(PH_RAW);
            end else if (fshift == ENC_COPY) begin
              enter_phase(PH_COPY);
            end else begin
              enter_phase(PH_HALT);
              r.kind = KIND_ERROR;
              r.error_code = ERR_ENCODING;
              has = 1'b1;
            end
          end
        end
        PH_RAW: begin
          if (!i[0]) begin
            lowb = b;
          end else begin
            lc = (col + 16'd1) == hw;
            lr = (row + 16'd1) == hh;
            r.kind = KIND_PIXEL;
            r.pos_x = hx + col;
            r.pos_y = hy + row;
            r.pixel_value = {b, lowb};
            r.row_end = lc;
            r.update_end = lc && lr && rleft == 16'd1;
            has = 1'b1;
            fidx = '0;
            if (lc) begin
              col = '0;
              row = row + 16'd1;
              if (lr) close_rect();
            end else begin
              col = col + 16'd1;
            end
          end
        end
        PH_COPY: begin
          if (i == IDX_COPY_SRC) begin
            r.kind = KIND_COPY;
            r.pos_x = hx;
            r.pos_y = hy;
            r.rect_width = hw;
            r.rect_height = hh;
            r.source_x = fshift[31:16];
            r.source_y = fshift[15:0];
            r.update_end = rleft == 16'd1;
            has = 1'b1;
            close_rect();
          end
        end
        PH_CMAP: begin
          if (i == IDX_CMAP_CNT) begin
            begin_skip(32'(fshift[15:0]) * 32'(CMAP_ENTRY_BYTES));
          end
        end
        PH_CUT: begin
          if (i == IDX_CUT_LEN) begin_skip(fshift);
        end
        PH_SKIP: begin
          skip = skip - 32'd1;
          if (skip == 32'd0) enter_phase(PH_TYPE);
        end
        default: enter_phase(PH_HALT);
      endcase
      if (has) pending_results.push_back(r);
    endfunction

    function void flag(string what, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        bad_words++;
        if (bad_words <= 10) begin
          $display("Mismatch in %s: expected %h, got %h", what, want, got);
        end
      end
    endfunction

    function void check_word(logic [M_DATA_W-1:0] d, logic [1:0] u, logic l);
      result_t want;
      if (pending_results.size() == 0) begin
        bad_words++;
        if (bad_words <= 10) begin
          $display("Unexpected result word: kind %h data %h last %b", u, d, l);
        end
        return;
      end
      want = pending_results.pop_front();
      flag("kind", 16'(want.kind), 16'(u));
      flag("pos_x", want.pos_x, d[15:0]);
      flag("pos_y", want.pos_y, d[31:16]);
      flag("pixel_value", want.pixel_value, d[47:32]);
      flag("rect_width", want.rect_width, d[63:48]);
      flag("rect_height", want.rect_height, d[79:64]);
      flag("source_x", want.source_x, d[95:80]);
      flag("source_y", want.source_y, d[111:96]);
      flag("row_end", 16'(want.row_end), 16'(d[ROW_END_BIT]));
      flag("update_end", 16'(want.update_end), 16'(l));
      flag("error_code", 16'(want.error_code), 16'(d[ERR_BIT]));
      flag("zero fill", 16'd0, 16'(d[M_DATA_W-1:ERR_BIT+1]));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic [7:0]          s_tdata = 8'd0;
  logic                s_tready;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [1:0]          m_tuser;
  logic                m_tlast;

  parse_tracker tracker;
  bit           idle_on = 1'b1;
  int           items_sent = 0;
  int           stall_left = 0;

  rfb_server_stream_parser_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) tracker.check_word(m_tdata, m_tuser, m_tlast);
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 13);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    #(2 * CLK_HALF * TIMEOUT_CYCLES);
    $display("Some tests failed");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk_i); while (!s_tready);
    tracker.take_byte(b);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pixel_byte();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] coord();
    if ($urandom_range(0, 3) == 0) return 16'hFFFF - 16'($urandom_range(0, 3));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_u16(input logic [15:0] v);
    push_byte(v[15:8]);
    push_byte(v[7:0]);
  endtask

  task automatic send_u32(input logic [31:0] v);
    send_u16(v[31:16]);
    send_u16(v[15:0]);
  endtask

  task automatic send_rect_hdr(input logic [15:0] x, y, w, h, input logic [31:0] enc);
    send_u16(x);
    send_u16(y);
    send_u16(w);
    send_u16(h);
    send_u32(enc);
  endtask

  task automatic send_fbu_hdr(input logic [15:0] n);
    push_byte(MSG_FBU);
    push_byte(8'($urandom_range(0, 255)));
    send_u16(n);
  endtask

  task automatic send_raw(input logic [15:0] x, y, w, h);
    send_rect_hdr(x, y, w, h, ENC_RAW);
    repeat (2 * int'(w) * int'(h)) push_byte(pixel_byte());
  endtask

  task automatic send_copy(input logic [15:0] x, y, w, h, sx, sy);
    send_rect_hdr(x, y, w, h, ENC_COPY);
    send_u16(sx);
    send_u16(sy);
  endtask

  task automatic send_cmap(input int count);
    push_byte(MSG_CMAP);
    push_byte(8'($urandom_range(0, 255)));
    send_u16(16'($urandom_range(0, 65535)));
    send_u16(16'(count));
    repeat (count * CMAP_ENTRY_BYTES) push_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_cut(input int len);
    push_byte(MSG_CUT);
    repeat (3) push_byte(8'($urandom_range(0, 255)));
    send_u32(32'(len));
    repeat (len) push_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_any_rect();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      if ($urandom_range(0, 1)) send_raw(coord(), coord(), 16'd0, coord());
      else send_raw(coord(), coord(), coord(), 16'd0);
    end else if (pick <= 2) begin
      send_copy(coord(), coord(), coord(), coord(), coord(), coord());
    end else if ($urandom_range(0, 15) == 0) begin
      send_raw(coord(), coord(), 16'($urandom_range(6, 40)), 16'd1);
    end else begin
      send_raw(coord(), coord(), 16'($urandom_range(1, 5)), 16'($urandom_range(1, 4)));
    end
  endtask

  task automatic send_update(input int n);
    send_fbu_hdr(16'(n));
    repeat (n) send_any_rect();
  endtask

  initial begin
    logic [31:0] enc;
    int          start;
    tracker = new();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: bell, empty update, wrapping raw and copy rectangles,
    // zero-area last rectangle, and zero-length and short skips.
    push_byte(MSG_BELL);
    send_fbu_hdr(16'd0);
    send_fbu_hdr(16'd2);
    send_raw(16'hFFFF, 16'hFFFE, 16'd2, 16'd2);
    send_copy(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
    send_fbu_hdr(16'd2);
    send_raw(16'd0, 16'd0, 16'd1, 16'd1);
    send_raw(16'd9, 16'd9, 16'd5, 16'd0);
    send_cmap(0);
    send_cut(0);
    send_cmap(1);
    send_cut(2);

    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (items_sent - start > RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
      else if ($urandom_range(0, 15) == 0) idle_on = !idle_on;
      case ($urandom_range(0, 9))
        6: send_cmap($urandom_range(0, 15) == 0 ? $urandom_range(5, 20) : $urandom_range(0, 4));
        7: send_cut($urandom_range(0, 10));
        8: push_byte(MSG_BELL);
        default: send_update($urandom_range(0, 3));
      endcase
    end

    // The run ends on a parser error; later bytes must be ignored.
    if ($urandom_range(0, 1)) begin
      push_byte(8'($urandom_range(4, 255)));
    end else begin
      do enc = $urandom; while (enc == ENC_RAW || enc == ENC_COPY);
      send_fbu_hdr(16'd1);
      send_rect_hdr(coord(), coord(), coord(), coord(), enc);
    end
    repeat (8) push_byte(8'($urandom_range(0, 255)));
    s_tvalid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.bad_words == 0 && tracker.pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/rfbp_pkg.sv
hw/rtl/rfbp_core.sv
hw/rtl/rfb_server_stream_parser_top.sv
hw/rtl/rfbp_checker.sv
tb/sv/testbench.sv
